### rtl/request_sequence_allocator_macros.svh
// Assertion macros shared by the request sequence allocator RTL.
// Depends on nothing; the files that assert include it by name.
`ifndef REQUEST_SEQUENCE_ALLOCATOR_MACROS_SVH
`define REQUEST_SEQUENCE_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("request sequence allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("request sequence allocator: next-cycle check failed");

`endif

### rtl/sra_pkg.sv
// Types and constants of the request sequence allocator.
// Used by the table cells, the free-number finder and the top level.
package sra_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int NETFN_W = 6;
   localparam int ADDR_W  = 8;
   localparam int CMD_W   = 8;
   localparam int TICK_W  = 64;
   localparam int DELAY_W = 32;
   localparam int SEQ_W   = 8;
   localparam int PREFIX_W = ADDR_W + NETFN_W + CMD_W;
   localparam int KEY_W    = PREFIX_W + SEQ_W;

   localparam int SEQ_LIMIT   = 255;
   localparam int POS_W       = 3;
   localparam int CHUNK_W     = 1 << POS_W;
   localparam int CHUNK_SEL_W = SEQ_W - POS_W;
   localparam int MAP_W       = 1 << SEQ_W;

   localparam logic [DELAY_W-1:0] RESET_HOLD_TICKS = 32'd6750;

   localparam logic [1:0] OUTCOME_PASS      = 2'd0;
   localparam logic [1:0] OUTCOME_ASSIGNED  = 2'd1;
   localparam logic [1:0] OUTCOME_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [TICK_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   typedef struct packed {
      logic             clear;
      logic             mark;
      logic [SEQ_W-1:0] mark_seq;
      logic             search;
   } finder_ctrl_type;

   typedef struct packed {
      logic             hit;
      logic             last;
      logic [SEQ_W-1:0] free_seq;
   } finder_stat_type;

endpackage

### rtl/sra_cell.sv
// One record of the allocation table, held in a ring of identical cells.
// Depends on sra_pkg for the record and control types.
module sra_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  sra_pkg::cell_ctrl_type ctrl,
   input  sra_pkg::entry_type     shift_in,
   input  sra_pkg::entry_type     load_in,
   output sra_pkg::entry_type     entry_out
);

   logic                       valid_ff, valid_in;
   logic [sra_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [sra_pkg::TICK_W-1:0] stamp_ff, stamp_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      stamp_in = stamp_ff;
      if (ctrl.load) begin
         valid_in = load_in.valid;
         key_in   = load_in.key;
         stamp_in = load_in.stamp;
      end else if (ctrl.shift) begin
         valid_in = shift_in.valid;
         key_in   = shift_in.key;
         stamp_in = shift_in.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      stamp_ff <= stamp_in;
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.key   = key_ff;
   assign entry_out.stamp = stamp_ff;

endmodule

### rtl/sra_free_finder.sv
// Map of sequence numbers in use for one key and a search for the lowest free one,
// one byte of the map per cycle. Depends on sra_pkg.
module sra_free_finder (
   input  logic                     clock,
   input  logic                     reset,
   input  sra_pkg::finder_ctrl_type ctrl,
   output sra_pkg::finder_stat_type stat
);

   logic [sra_pkg::MAP_W-1:0]       used_ff, used_in;
   logic [sra_pkg::CHUNK_SEL_W-1:0] chunk_ff, chunk_in;
   logic [sra_pkg::CHUNK_W-1:0]     byte_used;
   logic [sra_pkg::CHUNK_W-1:0]     byte_free;
   logic [sra_pkg::POS_W-1:0]       pos;
   logic [sra_pkg::SEQ_W-1:0]       full_seq;

   always_comb begin
      byte_used = used_ff[{chunk_ff, {sra_pkg::POS_W{1'b0}}} +: sra_pkg::CHUNK_W];
      for (int b = 0; b < sra_pkg::CHUNK_W; b++) begin
         full_seq = {chunk_ff, sra_pkg::POS_W'(b)};
         // Number zero and numbers from the limit up are never handed out.
         byte_free[b] = !byte_used[b] && (full_seq != '0) &&
                        (full_seq < sra_pkg::SEQ_W'(sra_pkg::SEQ_LIMIT));
      end
      pos = '0;
      for (int b = sra_pkg::CHUNK_W - 1; b >= 0; b--) begin
         if (byte_free[b]) begin
            pos = sra_pkg::POS_W'(b);
         end
      end
   end

   assign stat.hit      = |byte_free;
   assign stat.last     = (chunk_ff == '1);
   assign stat.free_seq = {chunk_ff, pos};

   always_comb begin
      used_in  = used_ff;
      chunk_in = chunk_ff;
      if (ctrl.clear) begin
         used_in  = '0;
         chunk_in = '0;
      end else begin
         if (ctrl.mark) begin
            used_in[ctrl.mark_seq] = 1'b1;
         end
         if (ctrl.search && !stat.hit && !stat.last) begin
            chunk_in = chunk_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         chunk_ff <= '0;
      end else begin
         used_ff  <= used_in;
         chunk_ff <= chunk_in;
      end
   end

endmodule

### rtl/request_sequence_allocator.sv
// Request sequence allocator: top level with the table ring, control and result register.
// Depends on sra_pkg, sra_cell, sra_free_finder and the assertion macro header.
//
// The block hands out sequence numbers for outgoing bus requests. A response header
// (netfn bit 0 set) passes straight through with outcome 0; it goes from the idle state
// straight to the done state, where its result is registered. A request walks the table
// ring once (the records rotate past a single head comparator, which drops expired records
// and marks the numbers in use for the request's key), then searches the in-use map, one
// byte per cycle, and in the done state posts the result and stores the new record. One
// request is worked on at a time; a new request is taken while an earlier result still
// waits on the result channel, and its own result then waits until that result has gone.
// Outcome 1 carries the assigned number; outcome 2 means no number or no table entry was
// free, though any expiry done for that request still holds.
// The reuse delay register may be written at any time the block is idle and resets to 6750.

`include "request_sequence_allocator_macros.svh"

module request_sequence_allocator (
   input  logic        clock,
   input  logic        reset,
   // Request channel. tdata, lowest bit up: netfn[5:0], responder_address[13:6],
   // command_code[21:14], now[85:22], zero padding[87:86].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,
   // Result channel. tdata, lowest bit up: outcome[1:0], sequence_res[9:2],
   // zero padding[15:10].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // Reuse delay register write port.
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int Depth = sra_pkg::TABLE_DEPTH;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [sra_pkg::DELAY_W-1:0] hold_ticks_ff;

   // Captured request.
   logic                          response_ff, response_in;
   logic [sra_pkg::PREFIX_W-1:0]  prefix_ff, prefix_in;
   logic [sra_pkg::TICK_W-1:0]    now_ff, now_in;
   logic [sra_pkg::TICK_W-1:0]    limit_ff, limit_in;
   logic                          expire_en_ff, expire_en_in;

   // Scan and search bookkeeping.
   logic [sra_pkg::IDX_W-1:0]     scan_ff, scan_in;
   logic [sra_pkg::IDX_W-1:0]     slot_ff, slot_in;
   logic                          slot_found_ff, slot_found_in;
   logic [sra_pkg::SEQ_W-1:0]     seq_ff, seq_in;
   logic                          exhausted_ff, exhausted_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    outcome_ff, outcome_in;
   logic [sra_pkg::SEQ_W-1:0]     rsp_seq_ff, rsp_seq_in;

   logic [sra_pkg::NETFN_W-1:0]   req_netfn;
   logic [sra_pkg::ADDR_W-1:0]    req_addr;
   logic [sra_pkg::CMD_W-1:0]     req_cmd;
   logic [sra_pkg::TICK_W-1:0]    req_now;
   logic                          req_fire;
   logic                          done_fire;
   logic [1:0]                    result_outcome;
   logic                          store_record;

   sra_pkg::entry_type            entries [Depth];
   sra_pkg::entry_type            head_next;
   sra_pkg::entry_type            load_entry;
   sra_pkg::finder_ctrl_type      finder_ctrl;
   sra_pkg::finder_stat_type      finder_stat;
   logic                          head_expire;
   logic                          head_match;

   assign req_netfn = req_tdata[5:0];
   assign req_addr  = req_tdata[13:6];
   assign req_cmd   = req_tdata[21:14];
   assign req_now   = req_tdata[85:22];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // The reuse delay register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= sra_pkg::RESET_HOLD_TICKS;
      end else if (csr_wr_en) begin
         hold_ticks_ff <= csr_wr_data;
      end
   end

   // The record at the head of the ring is checked for expiry and for a key match as it
   // wraps round to the tail, so one full rotation visits every record once.
   assign head_expire = expire_en_ff && (entries[0].stamp < limit_ff);
   always_comb begin
      head_next       = entries[0];
      head_next.valid = entries[0].valid && !head_expire;
   end
   assign head_match = head_next.valid &&
                       (head_next.key[sra_pkg::KEY_W-1:sra_pkg::SEQ_W] == prefix_ff);

   assign load_entry.valid = 1'b1;
   assign load_entry.key   = {prefix_ff, seq_ff};
   assign load_entry.stamp = now_ff;

   genvar gi;
   generate
      for (gi = 0; gi < Depth; gi++) begin : g_cell
         sra_pkg::cell_ctrl_type cell_ctrl;
         sra_pkg::entry_type     cell_shift_in;

         assign cell_ctrl.shift = (state_ff == ST_SCAN);
         assign cell_ctrl.load  = store_record && (slot_ff == sra_pkg::IDX_W'(gi));

         if (gi == Depth - 1) begin : g_tail
            assign cell_shift_in = head_next;
         end else begin : g_body
            assign cell_shift_in = entries[gi + 1];
         end

         sra_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .shift_in  (cell_shift_in),
            .load_in   (load_entry),
            .entry_out (entries[gi])
         );
      end
   endgenerate

   assign finder_ctrl.clear    = req_fire;
   assign finder_ctrl.mark     = (state_ff == ST_SCAN) && head_match;
   assign finder_ctrl.mark_seq = head_next.key[sra_pkg::SEQ_W-1:0];
   assign finder_ctrl.search   = (state_ff == ST_SEARCH);

   sra_free_finder u_finder (
      .clock (clock),
      .reset (reset),
      .ctrl  (finder_ctrl),
      .stat  (finder_stat)
   );

   // The result is posted once the result register is free or being emptied.
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (response_ff) begin
         result_outcome = sra_pkg::OUTCOME_PASS;
      end else if (exhausted_ff || !slot_found_ff) begin
         result_outcome = sra_pkg::OUTCOME_EXHAUSTED;
      end else begin
         result_outcome = sra_pkg::OUTCOME_ASSIGNED;
      end
   end

   assign store_record = done_fire && (result_outcome == sra_pkg::OUTCOME_ASSIGNED);

   always_comb begin
      state_in      = state_ff;
      response_in   = response_ff;
      prefix_in     = prefix_ff;
      now_in        = now_ff;
      limit_in      = limit_ff;
      expire_en_in  = expire_en_ff;
      scan_in       = scan_ff;
      slot_in       = slot_ff;
      slot_found_in = slot_found_ff;
      seq_in        = seq_ff;
      exhausted_in  = exhausted_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      outcome_in    = outcome_ff;
      rsp_seq_in    = rsp_seq_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               response_in   = req_netfn[0];
               prefix_in     = {req_addr, req_netfn, req_cmd};
               now_in        = req_now;
               limit_in      = req_now - {{(sra_pkg::TICK_W - sra_pkg::DELAY_W){1'b0}},
                                          hold_ticks_ff};
               expire_en_in  = req_now > {{(sra_pkg::TICK_W - sra_pkg::DELAY_W){1'b0}},
                                          hold_ticks_ff};
               scan_in       = '0;
               slot_found_in = 1'b0;
               exhausted_in  = 1'b0;
               state_in      = req_netfn[0] ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The lowest-indexed entry left invalid after expiry takes the new record.
            if (!slot_found_ff && !head_next.valid) begin
               slot_found_in = 1'b1;
               slot_in       = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == sra_pkg::IDX_W'(Depth - 1)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (finder_stat.hit) begin
               seq_in   = finder_stat.free_seq;
               state_in = ST_DONE;
            end else if (finder_stat.last) begin
               exhausted_in = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               rsp_valid_in = 1'b1;
               outcome_in   = result_outcome;
               rsp_seq_in   = (result_outcome == sra_pkg::OUTCOME_ASSIGNED) ? seq_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      response_ff   <= response_in;
      prefix_ff     <= prefix_in;
      now_ff        <= now_in;
      limit_ff      <= limit_in;
      expire_en_ff  <= expire_en_in;
      scan_ff       <= scan_in;
      slot_ff       <= slot_in;
      slot_found_ff <= slot_found_in;
      seq_ff        <= seq_in;
      exhausted_ff  <= exhausted_in;
      outcome_ff    <= outcome_in;
      rsp_seq_ff    <= rsp_seq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_seq_ff, outcome_ff};

   // An assigned number always lies between one and the limit.
   `SRA_ASSERT_SAME(a_assigned_range, clock, reset,
      rsp_valid_ff && (outcome_ff == sra_pkg::OUTCOME_ASSIGNED),
      (rsp_seq_ff != '0) && (rsp_seq_ff < sra_pkg::SEQ_W'(sra_pkg::SEQ_LIMIT)))
   // Any other outcome carries number zero.
   `SRA_ASSERT_SAME(a_unassigned_zero, clock, reset,
      rsp_valid_ff && (outcome_ff != sra_pkg::OUTCOME_ASSIGNED), rsp_seq_ff == '0)
   // Only one request is in work at a time.
   `SRA_ASSERT_NEXT(a_one_in_work, clock, reset, req_fire, !req_tready)
   // A record is only stored into an entry found free during the scan.
   `SRA_ASSERT_SAME(a_store_free_slot, clock, reset, store_record,
      slot_found_ff && !exhausted_ff && !response_ff)

endmodule

### bench/sequence_grant_checker.sv
// Checker for the request sequence allocator: watches both streams and the register port,
// predicts every result and compares it. Depends on sra_pkg for widths and outcome codes.
`timescale 1ns / 100ps

module sequence_grant_checker
   import sra_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [87:0]        req_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [15:0]        rsp_tdata,
   input  logic               csr_wr_en,
   input  logic [DELAY_W-1:0] csr_wr_data,
   output int                 outstanding,
   output int                 failures
);

   typedef struct packed {
      logic [1:0]       outcome;
      logic [SEQ_W-1:0] number;
   } grant_type;

   // Own copy of the register and of the record table.
   logic [DELAY_W-1:0] hold_ticks;
   logic               rec_live  [TABLE_DEPTH];
   logic [KEY_W-1:0]   rec_key   [TABLE_DEPTH];
   logic [TICK_W-1:0]  rec_stamp [TABLE_DEPTH];
   grant_type          pending_grants [$];

   // Works out the grant for one request header and updates the table as the block should.
   function automatic grant_type allocate_sequence(input logic [NETFN_W-1:0] netfn,
                                                   input logic [ADDR_W-1:0]  addr,
                                                   input logic [CMD_W-1:0]   cmd,
                                                   input logic [TICK_W-1:0]  now);
      grant_type            grant;
      logic [TICK_W-1:0]    cutoff;
      logic [PREFIX_W-1:0]  prefix;
      logic [MAP_W-1:0]     taken;
      int                   slot;
      int                   seq;
      grant = '0;
      if (netfn[0]) begin
         grant.outcome = OUTCOME_PASS;
         return grant;
      end
      // Records stamped before now minus the delay are dropped first.
      if (now > {{(TICK_W-DELAY_W){1'b0}}, hold_ticks}) begin
         cutoff = now - {{(TICK_W-DELAY_W){1'b0}}, hold_ticks};
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (rec_live[i] && rec_stamp[i] < cutoff) rec_live[i] = 1'b0;
         end
      end
      prefix = {addr, netfn, cmd};
      taken  = '0;
      slot   = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (rec_live[i]) begin
            if (rec_key[i][KEY_W-1:SEQ_W] == prefix) taken[rec_key[i][SEQ_W-1:0]] = 1'b1;
         end else if (slot < 0) begin
            slot = i;
         end
      end
      seq = 1;
      while (seq < SEQ_LIMIT && taken[seq]) seq++;
      if (seq >= SEQ_LIMIT || slot < 0) begin
         grant.outcome = OUTCOME_EXHAUSTED;
         return grant;
      end
      rec_live[slot]  = 1'b1;
      rec_key[slot]   = {prefix, seq[SEQ_W-1:0]};
      rec_stamp[slot] = now;
      grant.outcome   = OUTCOME_ASSIGNED;
      grant.number    = seq[SEQ_W-1:0];
      return grant;
   endfunction

   always @(posedge clock) begin : observe
      grant_type want;
      grant_type got;
      grant_type predicted;
      if (reset) begin
         hold_ticks = RESET_HOLD_TICKS;
         for (int i = 0; i < TABLE_DEPTH; i++) rec_live[i] = 1'b0;
         pending_grants.delete();
         failures = 0;
      end else begin
         if (csr_wr_en) hold_ticks = csr_wr_data;
         if (req_tvalid && req_tready) begin
            predicted = allocate_sequence(req_tdata[5:0], req_tdata[13:6],
                                          req_tdata[21:14], req_tdata[85:22]);
            pending_grants.insert(pending_grants.size(), predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.outcome = rsp_tdata[1:0];
            got.number  = rsp_tdata[9:2];
            if (pending_grants.size() == 0) begin
               if (failures < 10)
                  $display("%0t: unexpected result outcome %0d sequence %0d", $time,
                           got.outcome, got.number);
               failures++;
            end else begin
               want = pending_grants.pop_front();
               if (got.outcome !== want.outcome || got.number !== want.number) begin
                  if (failures < 10)
                     $display({"%0t: expected outcome %0d sequence %0d, ",
                               "got outcome %0d sequence %0d"},
                              $time, want.outcome, want.number, got.outcome, got.number);
                  failures++;
               end
            end
         end
      end
      outstanding <= pending_grants.size();
   end

endmodule

### bench/tb.sv
// Top of the request sequence allocator testbench: clock, reset, stimulus and verdict.
// Depends on sra_pkg, the allocator RTL and sequence_grant_checker in this folder.
`timescale 1ns / 100ps

module tb;
   import sra_pkg::*;

   // Cycles of quiet after the last result before the verdict or a register write. The
   // slowest request walks the ring and searches the whole map in well under this.
   localparam int SETTLE_CYCLES = 80;
   // The watchdog gives up after this many cycles in which neither stream moves. The long
   // hold-off of the result channel is far shorter, so this leaves a wide margin.
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 130;
   localparam int POOL_SIZE     = 3;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // Lowest bit up: netfn, responder_address, command_code, now, two bits of padding.
   logic [87:0]         req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // Lowest bit up: outcome, sequence_res, six bits of padding.
   logic [15:0]         rsp_tdata;
   logic                csr_wr_en;
   logic [DELAY_W-1:0]  csr_wr_data;

   int                  outstanding;
   int                  failures;

   // Set by the stimulus once, mid-phase, to ask the result side for its long hold-off.
   bit                  squeeze_req;
   // When set, the sender offers requests back to back.
   bit                  sender_fast;
   // Running tick count handed out with the requests.
   logic [TICK_W-1:0]   tick;
   logic [NETFN_W-1:0]  pool_netfn [POOL_SIZE];
   logic [ADDR_W-1:0]   pool_addr  [POOL_SIZE];
   logic [CMD_W-1:0]    pool_cmd   [POOL_SIZE];

   request_sequence_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sequence_grant_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .outstanding (outstanding),
      .failures    (failures)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offers one request after a random gap and returns at the edge that takes it. The
   // valid line stays high across back-to-back requests, so it is only lowered for a gap.
   task automatic send_request(input logic [NETFN_W-1:0] netfn,
                               input logic [ADDR_W-1:0]  addr,
                               input logic [CMD_W-1:0]   cmd,
                               input logic [TICK_W-1:0]  now);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {2'b00, now, cmd, addr, netfn};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every predicted result has been taken, then lets the
   // block settle. The first edge is skipped because the checker's count is registered.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_hold_ticks(input logic [DELAY_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random request. Most use a small pool of keys with a slowly rising tick so that
   // numbers pile up, records expire and the table fills; the rest are response headers
   // and fully random headers, with the tick now and then jumping to any 64-bit value.
   task automatic random_request(input int step_max);
      int                 kind;
      int                 k;
      logic [NETFN_W-1:0] netfn;
      logic [ADDR_W-1:0]  addr;
      logic [CMD_W-1:0]   cmd;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) tick = {$urandom, $urandom};
      else tick = tick + TICK_W'($urandom_range(0, step_max));
      if (kind < 10) begin
         netfn    = NETFN_W'($urandom);
         netfn[0] = 1'b1;
         addr     = ADDR_W'($urandom);
         cmd      = CMD_W'($urandom);
      end else if (kind < 25) begin
         netfn = NETFN_W'($urandom);
         addr  = ADDR_W'($urandom);
         cmd   = CMD_W'($urandom);
      end else begin
         k     = $urandom_range(0, POOL_SIZE - 1);
         netfn = pool_netfn[k];
         addr  = pool_addr[k];
         cmd   = pool_cmd[k];
      end
      send_request(netfn, addr, cmd, tick);
   endtask

   // Result side: a random stall before each result, with stretches of none, and one long
   // hold-off on request so that the block fills up and has to stall its input.
   initial begin : result_sink
      int stall;
      int taken;
      bit fast;
      bit squeeze_done;
      rsp_tready   = 1'b0;
      taken        = 0;
      fast         = 1'b0;
      squeeze_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 50 == 0) fast = ($urandom_range(0, 2) == 0);
         stall = fast ? 0 : $urandom_range(0, 4);
         if (squeeze_req && !squeeze_done) begin
            stall        = 400;
            squeeze_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   // Ends the run if neither stream moves for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      logic [DELAY_W-1:0] delay;
      int                 step_max;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      squeeze_req = 1'b0;
      sender_fast = 1'b0;
      tick        = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset value of the delay. Response headers at both ends
      // of the fields pass straight through.
      send_request(6'd1, 8'h00, 8'h00, 64'd0);
      send_request(6'd63, 8'hFF, 8'hFF, '1);
      // Numbers are handed out from the lowest upwards, separately for each key.
      send_request(6'd0, 8'h00, 8'h00, 64'd0);
      send_request(6'd0, 8'h00, 8'h00, 64'd1);
      send_request(6'd62, 8'hFF, 8'hFF, 64'd2);
      // A tick equal to the delay expires nothing; one and two beyond it drop the oldest
      // records, so their numbers come free again.
      send_request(6'd0, 8'h00, 8'h00, 64'd6750);
      send_request(6'd0, 8'h00, 8'h00, 64'd6751);
      send_request(6'd0, 8'h00, 8'h00, 64'd6752);
      // The largest tick expires every record.
      send_request(6'd62, 8'hFF, 8'hFF, '1);
      send_request(6'd42, 8'hAA, 8'h55, 64'h5555_5555_5555_5555);
      send_request(6'd21, 8'h55, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(6'd20, 8'h55, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA);
      drain();

      // Random phases, each under its own delay: the largest delay keeps records so long that
      // the table fills and requests are refused, a zero delay frees records one tick on,
      // and the steps of the tick are sized so that the table is often near full.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin delay = '1;                step_max = 50;  end
            1: begin delay = '0;                step_max = 3;   end
            2: begin delay = 32'd20;            step_max = 8;   end
            3: begin delay = 32'd150;           step_max = 20;  end
            4: begin delay = 32'd1000;          step_max = 60;  end
            5: begin delay = $urandom;          step_max = 300; end
            default: begin delay = RESET_HOLD_TICKS; step_max = 400; end
         endcase
         write_hold_ticks(delay);
         for (int k = 0; k < POOL_SIZE; k++) begin
            pool_netfn[k] = NETFN_W'($urandom_range(0, 31) * 2);
            pool_addr[k]  = ADDR_W'($urandom);
            pool_cmd[k]   = CMD_W'($urandom);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) sender_fast = ($urandom_range(0, 2) == 0);
            if (p == 2 && n == 40) squeeze_req = 1'b1;
            random_request(step_max);
         end
         drain();
      end

      if (failures == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
